[rtl/emt_pkg.sv]
// ============================================================================
// emt_pkg
// shared widths, constants and types of the encoder multiturn tracker
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package emt_pkg;

    localparam int RAW_W       = 12;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int TRACK_W     = 36;
    localparam int VEL_W       = 35;
    localparam int US_W        = 32;
    localparam int DIFF_W      = 37;
    localparam int MUL_A_W     = 33;
    localparam int MUL_B_W     = 21;
    localparam int MUL_P_W     = 55;
    localparam int MAG_SPLIT   = 19;
    localparam int ACC_W       = 39;
    localparam int DIVIDEND_W  = 57;
    localparam int QUO_W       = 35;
    localparam int DIV_CNT_W   = 6;

    localparam logic [MUL_B_W-1:0] US_PER_S      = 21'd1000000;
    localparam logic [RAW_W-1:0]   WRAP_RESET    = 12'd3276;
    localparam logic [VEL_W-1:0]   VEL_POS_LIM   = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0]   VEL_NEG_LIM   = {1'b1, {(VEL_W-1){1'b0}}};

    localparam logic OP_SEED   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_UNWRAP = 12'b0000_0000_0010,
        ST_MULTRK = 12'b0000_0000_0100,
        ST_TRACK  = 12'b0000_0000_1000,
        ST_DIFF   = 12'b0000_0001_0000,
        ST_MULLO  = 12'b0000_0010_0000,
        ST_MULHI  = 12'b0000_0100_0000,
        ST_SUM    = 12'b0000_1000_0000,
        ST_CHECK  = 12'b0001_0000_0000,
        ST_DIV    = 12'b0010_0000_0000,
        ST_FIN    = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

[rtl/emt_mul.sv]
// ============================================================================
// emt_mul
// shared signed by unsigned multiplier with registered product
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module emt_mul (
    input  wire                                 clk,
    input  wire  signed [emt_pkg::MUL_A_W-1:0]  a,
    input  wire         [emt_pkg::MUL_B_W-1:0]  b,
    output logic signed [emt_pkg::MUL_P_W-1:0]  p
);

    logic signed [emt_pkg::MUL_B_W:0]   b_s;
    logic signed [emt_pkg::MUL_P_W-1:0] p_next;

    assign b_s    = $signed({1'b0, b});
    assign p_next = emt_pkg::MUL_P_W'(a * b_s);

    always_ff @(posedge clk)
    begin
        p <= p_next;
    end

endmodule

`default_nettype wire

[rtl/emt_div.sv]
// ============================================================================
// emt_div
// restoring serial divider, one quotient bit per cycle
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module emt_div (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [emt_pkg::US_W-1:0]         rem_init,
    input  wire  [emt_pkg::QUO_W-1:0]        num,
    input  wire  [emt_pkg::US_W-1:0]         den,
    output logic                             done,
    output logic [emt_pkg::QUO_W-1:0]        quo
);

    logic [emt_pkg::US_W-1:0]      rem_reg,  rem_next;
    logic [emt_pkg::QUO_W-1:0]     sh_reg,   sh_next;
    logic [emt_pkg::US_W-1:0]      den_reg,  den_next;
    logic [emt_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                          done_reg, done_next;
    logic [emt_pkg::US_W:0]        partial;
    logic [emt_pkg::US_W:0]        trial;

    assign partial = {rem_reg, sh_reg[emt_pkg::QUO_W-1]};
    assign trial   = partial - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = rem_init;
            sh_next  = num;
            den_next = den;
            cnt_next = emt_pkg::DIV_CNT_W'(emt_pkg::QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            if (partial >= {1'b0, den_reg})
            begin
                rem_next = trial[emt_pkg::US_W-1:0];
                sh_next  = {sh_reg[emt_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[emt_pkg::US_W-1:0];
                sh_next  = {sh_reg[emt_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == emt_pkg::DIV_CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

`default_nettype wire

[rtl/encoder_multiturn_tracker_top.sv]
// ============================================================================
// encoder_multiturn_tracker_top
// multiturn unwrap and raw velocity for a 12-bit absolute shaft encoder
// ============================================================================
// latency from accept to out_valid follows the path: a failed read or seed item goes
// straight to done; an update runs unwrap, track, difference, the multiplier passes,
// sum, overflow check and divider, ending after the difference on a zero step or zero
// elapsed time and at the check on an overflow. one item at a time; a divided update
// is held by the 35-step serial divider; a result waits in done while full
// reset: asynchronous active low, clears tracking state, threshold to 3276
`timescale 1ns / 1ps
`default_nettype none

module encoder_multiturn_tracker_top #(
    parameter int COUNTS_PER_TURN = 4096,
    parameter int TURN_BITS       = 24
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire  [emt_pkg::RAW_W-1:0]             cfg_wdata,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire                                   opcode,
    input  wire                                   read_ok,
    input  wire  [emt_pkg::BYTE_W-1:0]            angle_high_byte,
    input  wire  [emt_pkg::BYTE_W-1:0]            angle_low_byte,
    input  wire  [emt_pkg::US_W-1:0]              elapsed_us,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic                                  fault,
    output logic [emt_pkg::RAW_W-1:0]             raw_count,
    output logic signed [emt_pkg::TRACK_W-1:0]    track_count,
    output logic signed [emt_pkg::VEL_W-1:0]      velocity_cps
);

    localparam int A_EXT = emt_pkg::MUL_A_W - TURN_BITS;

    emt_pkg::state_t state_reg, state_next;

    logic [emt_pkg::RAW_W-1:0]     thr_reg, thr_next;
    logic [emt_pkg::RAW_W-1:0]     last_raw_reg, last_raw_next;
    logic [TURN_BITS-1:0]          turn_reg, turn_next;
    logic [emt_pkg::TRACK_W-1:0]   last_track_reg, last_track_next;
    logic [emt_pkg::VEL_W-1:0]     last_vel_reg, last_vel_next;

    logic [emt_pkg::RAW_W-1:0]     raw_reg, raw_next;
    logic [emt_pkg::US_W-1:0]      us_reg, us_next;
    logic                          flt_reg, flt_next;
    logic                          neg_reg, neg_next;
    logic [emt_pkg::DIFF_W-1:0]    mag_reg, mag_next;
    logic [emt_pkg::TRACK_W-1:0]   track_reg, track_next;
    logic [emt_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [emt_pkg::DIVIDEND_W-1:0] dvd_reg, dvd_next;

    logic                          ovalid_reg, ovalid_next;
    logic                          ofault_reg, ofault_next;
    logic [emt_pkg::RAW_W-1:0]     oraw_reg, oraw_next;
    logic [emt_pkg::TRACK_W-1:0]   otrack_reg, otrack_next;
    logic [emt_pkg::VEL_W-1:0]     ovel_reg, ovel_next;

    logic [emt_pkg::RAW_W-1:0]     raw_in;
    logic signed [emt_pkg::RAW_W:0] d;
    logic [emt_pkg::RAW_W-1:0]     ad;
    logic signed [emt_pkg::DIFF_W-1:0] diff;
    logic                          accept;
    logic                          out_load;

    logic signed [emt_pkg::MUL_A_W-1:0] mul_a;
    logic [emt_pkg::MUL_B_W-1:0]        mul_b;
    logic signed [emt_pkg::MUL_P_W-1:0] mul_p;

    logic                          div_start;
    logic                          div_done;
    logic [emt_pkg::QUO_W-1:0]     div_quo;

    emt_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    emt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (emt_pkg::US_W'(dvd_reg[emt_pkg::DIVIDEND_W-1:emt_pkg::QUO_W])),
        .num      (dvd_reg[emt_pkg::QUO_W-1:0]),
        .den      (us_reg),
        .done     (div_done),
        .quo      (div_quo)
    );

    assign in_ready = (state_reg == emt_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == emt_pkg::ST_DONE) && (!ovalid_reg || out_ready);

    assign raw_in = {angle_high_byte[emt_pkg::NIB_W-1:0], angle_low_byte};
    assign d      = $signed({1'b0, raw_reg}) - $signed({1'b0, last_raw_reg});
    assign ad     = d[emt_pkg::RAW_W] ? emt_pkg::RAW_W'(-d) : d[emt_pkg::RAW_W-1:0];
    assign diff   = $signed({track_reg[emt_pkg::TRACK_W-1], track_reg})
                  - $signed({last_track_reg[emt_pkg::TRACK_W-1], last_track_reg});

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            emt_pkg::ST_MULTRK:
            begin
                mul_a = $signed({{A_EXT{turn_reg[TURN_BITS-1]}}, turn_reg});
                mul_b = emt_pkg::MUL_B_W'(COUNTS_PER_TURN);
            end
            emt_pkg::ST_MULLO:
            begin
                mul_a = $signed(emt_pkg::MUL_A_W'(mag_reg[emt_pkg::MAG_SPLIT-1:0]));
                mul_b = emt_pkg::US_PER_S;
            end
            emt_pkg::ST_MULHI:
            begin
                mul_a = $signed(emt_pkg::MUL_A_W'(
                            mag_reg[emt_pkg::DIFF_W-1:emt_pkg::MAG_SPLIT]));
                mul_b = emt_pkg::US_PER_S;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        thr_next        = cfg_we ? cfg_wdata : thr_reg;
        last_raw_next   = last_raw_reg;
        turn_next       = turn_reg;
        last_track_next = last_track_reg;
        last_vel_next   = last_vel_reg;
        raw_next        = raw_reg;
        us_next         = us_reg;
        flt_next        = flt_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        track_next      = track_reg;
        acc_next        = acc_reg;
        dvd_next        = dvd_reg;
        div_start       = 1'b0;

        case (state_reg)
            emt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    raw_next = raw_in;
                    us_next  = elapsed_us;
                    flt_next = !read_ok;
                    if (!read_ok)
                    begin
                        state_next = emt_pkg::ST_DONE;
                    end
                    else if (opcode == emt_pkg::OP_SEED)
                    begin
                        last_raw_next   = raw_in;
                        turn_next       = '0;
                        last_track_next = emt_pkg::TRACK_W'(raw_in);
                        last_vel_next   = '0;
                        state_next      = emt_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = emt_pkg::ST_UNWRAP;
                    end
                end
            end
            emt_pkg::ST_UNWRAP:
            begin
                if (ad > thr_reg)
                begin
                    // jump past threshold: one turn against the jump direction
                    turn_next = d[emt_pkg::RAW_W] ? turn_reg + 1'b1 : turn_reg - 1'b1;
                end
                last_raw_next = raw_reg;
                state_next    = emt_pkg::ST_MULTRK;
            end
            emt_pkg::ST_MULTRK:
            begin
                state_next = emt_pkg::ST_TRACK;
            end
            emt_pkg::ST_TRACK:
            begin
                track_next = mul_p[emt_pkg::TRACK_W-1:0] + emt_pkg::TRACK_W'(raw_reg);
                state_next = emt_pkg::ST_DIFF;
            end
            emt_pkg::ST_DIFF:
            begin
                neg_next        = diff[emt_pkg::DIFF_W-1];
                mag_next        = diff[emt_pkg::DIFF_W-1] ? emt_pkg::DIFF_W'(-diff)
                                                          : diff;
                last_track_next = track_reg;
                if (diff == '0)
                begin
                    last_vel_next = '0;
                    state_next    = emt_pkg::ST_DONE;
                end
                else if (us_reg == '0)
                begin
                    last_vel_next = diff[emt_pkg::DIFF_W-1] ? emt_pkg::VEL_NEG_LIM
                                                            : emt_pkg::VEL_POS_LIM;
                    state_next    = emt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = emt_pkg::ST_MULLO;
                end
            end
            emt_pkg::ST_MULLO:
            begin
                state_next = emt_pkg::ST_MULHI;
            end
            emt_pkg::ST_MULHI:
            begin
                acc_next   = mul_p[emt_pkg::ACC_W-1:0];
                state_next = emt_pkg::ST_SUM;
            end
            emt_pkg::ST_SUM:
            begin
                dvd_next   = emt_pkg::DIVIDEND_W'(acc_reg)
                           + (emt_pkg::DIVIDEND_W'(
                                  mul_p[emt_pkg::DIVIDEND_W-emt_pkg::MAG_SPLIT-1:0])
                              << emt_pkg::MAG_SPLIT);
                state_next = emt_pkg::ST_CHECK;
            end
            emt_pkg::ST_CHECK:
            begin
                // quotient too wide for the output when top part reaches divisor
                if (emt_pkg::US_W'(dvd_reg[emt_pkg::DIVIDEND_W-1:emt_pkg::QUO_W])
                    >= us_reg)
                begin
                    last_vel_next = neg_reg ? emt_pkg::VEL_NEG_LIM : emt_pkg::VEL_POS_LIM;
                    state_next    = emt_pkg::ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = emt_pkg::ST_DIV;
                end
            end
            emt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = emt_pkg::ST_FIN;
                end
            end
            emt_pkg::ST_FIN:
            begin
                if (div_quo[emt_pkg::QUO_W-1])
                begin
                    last_vel_next = neg_reg ? emt_pkg::VEL_NEG_LIM : emt_pkg::VEL_POS_LIM;
                end
                else
                begin
                    last_vel_next = neg_reg ? emt_pkg::VEL_W'(-div_quo) : div_quo;
                end
                state_next = emt_pkg::ST_DONE;
            end
            emt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = emt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = emt_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        ofault_next = ofault_reg;
        oraw_next   = oraw_reg;
        otrack_next = otrack_reg;
        ovel_next   = ovel_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (out_load)
        begin
            ovalid_next = 1'b1;
            ofault_next = flt_reg;
            oraw_next   = last_raw_reg;
            otrack_next = last_track_reg;
            ovel_next   = last_vel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= emt_pkg::ST_IDLE;
            thr_reg        <= emt_pkg::WRAP_RESET;
            last_raw_reg   <= '0;
            turn_reg       <= '0;
            last_track_reg <= '0;
            last_vel_reg   <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            last_raw_reg   <= last_raw_next;
            turn_reg       <= turn_next;
            last_track_reg <= last_track_next;
            last_vel_reg   <= last_vel_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= raw_next;
        us_reg     <= us_next;
        flt_reg    <= flt_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        track_reg  <= track_next;
        acc_reg    <= acc_next;
        dvd_reg    <= dvd_next;
        ofault_reg <= ofault_next;
        oraw_reg   <= oraw_next;
        otrack_reg <= otrack_next;
        ovel_reg   <= ovel_next;
    end

    assign out_valid    = ovalid_reg;
    assign fault        = ofault_reg;
    assign raw_count    = oraw_reg;
    assign track_count  = $signed(otrack_reg);
    assign velocity_cps = $signed(ovel_reg);

endmodule

`default_nettype wire

[sim/encoder_multiturn_tracker_top_test.sv]
// ============================================================================
// encoder_multiturn_tracker_top_test
// drives encoder samples through the multiturn tracker and compares every
// result item with an in-bench tracker model: directed corner items first,
// then runs of spinning-shaft samples under several wrap thresholds and
// varying back-pressure on both channels
// ============================================================================
`timescale 1ns / 1ps

module encoder_multiturn_tracker_top_test;

    localparam int COUNTS      = 4096;
    localparam int TURN_W      = 24;
    localparam int STALL_LIMIT = 4000;
    localparam int RUN_ITEMS   = 275;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic                       opcode;
        logic                       read_ok;
        logic [emt_pkg::BYTE_W-1:0] angle_high_byte;
        logic [emt_pkg::BYTE_W-1:0] angle_low_byte;
        logic [emt_pkg::US_W-1:0]   elapsed_us;
    } sample_t;

    typedef struct {
        logic                               fault;
        logic [emt_pkg::RAW_W-1:0]          raw_count;
        logic signed [emt_pkg::TRACK_W-1:0] track_count;
        logic signed [emt_pkg::VEL_W-1:0]   velocity_cps;
    } position_t;

    logic                               clk;
    logic                               rst_n           = 1'b0;
    logic                               cfg_we          = 1'b0;
    logic [emt_pkg::RAW_W-1:0]          cfg_wdata       = emt_pkg::WRAP_RESET;
    logic                               in_valid        = 1'b0;
    logic                               in_ready;
    logic                               opcode          = emt_pkg::OP_SEED;
    logic                               read_ok         = 1'b0;
    logic [emt_pkg::BYTE_W-1:0]         angle_high_byte = '0;
    logic [emt_pkg::BYTE_W-1:0]         angle_low_byte  = '0;
    logic [emt_pkg::US_W-1:0]           elapsed_us      = '0;
    logic                               out_valid;
    logic                               out_ready       = 1'b0;
    logic                               fault;
    logic [emt_pkg::RAW_W-1:0]          raw_count;
    logic signed [emt_pkg::TRACK_W-1:0] track_count;
    logic signed [emt_pkg::VEL_W-1:0]   velocity_cps;

    // tracker model state
    logic [emt_pkg::RAW_W-1:0]          wrap_thr   = emt_pkg::WRAP_RESET;
    logic [emt_pkg::RAW_W-1:0]          trk_raw    = '0;
    logic signed [TURN_W-1:0]           trk_turns  = '0;
    logic signed [emt_pkg::TRACK_W-1:0] trk_pos    = '0;
    logic signed [emt_pkg::VEL_W-1:0]   trk_vel    = '0;

    sample_t   sample_queue[$];
    position_t expected_positions[$];
    sample_t   cur_sample;
    int        in_flight      = 0;
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;
    int        rx_hold_left   = 0;
    int        stall_cycles   = 0;
    int        shaft          = 0;

    encoder_multiturn_tracker_top #(
        .COUNTS_PER_TURN (COUNTS),
        .TURN_BITS       (TURN_W)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .read_ok         (read_ok),
        .angle_high_byte (angle_high_byte),
        .angle_low_byte  (angle_low_byte),
        .elapsed_us      (elapsed_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fault           (fault),
        .raw_count       (raw_count),
        .track_count     (track_count),
        .velocity_cps    (velocity_cps)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [emt_pkg::VEL_W-1:0] rate_cps(
        longint step, logic [emt_pkg::US_W-1:0] us);
        logic [63:0] mag;
        logic [63:0] quo;
        if (step == 0)
            return '0;
        if (us == '0)
            return (step < 0) ? emt_pkg::VEL_NEG_LIM : emt_pkg::VEL_POS_LIM;
        mag = (step < 0) ? -step : step;
        quo = (mag * emt_pkg::US_PER_S) / {32'd0, us};
        if (quo > emt_pkg::VEL_POS_LIM)
            return (step < 0) ? emt_pkg::VEL_NEG_LIM : emt_pkg::VEL_POS_LIM;
        return (step < 0) ? -quo[emt_pkg::VEL_W-1:0] : quo[emt_pkg::VEL_W-1:0];
    endfunction

    function automatic position_t advance_tracker(sample_t s);
        position_t                          r;
        logic [emt_pkg::RAW_W-1:0]          raw;
        longint                             jump;
        longint                             pos;
        logic signed [emt_pkg::TRACK_W-1:0] new_pos;
        raw = {s.angle_high_byte[emt_pkg::NIB_W-1:0], s.angle_low_byte};
        r.fault = !s.read_ok;
        if (s.read_ok && s.opcode == emt_pkg::OP_SEED)
        begin
            trk_raw   = raw;
            trk_turns = '0;
            trk_pos   = {{(emt_pkg::TRACK_W-emt_pkg::RAW_W){1'b0}}, raw};
            trk_vel   = '0;
        end
        else if (s.read_ok)
        begin
            jump = longint'(raw) - longint'(trk_raw);
            if (((jump < 0) ? -jump : jump) > longint'(wrap_thr))
            begin
                if (jump > 0)
                    trk_turns = trk_turns - 1;
                else
                    trk_turns = trk_turns + 1;
            end
            pos     = longint'(trk_turns) * COUNTS + longint'(raw);
            new_pos = pos[emt_pkg::TRACK_W-1:0];
            trk_vel = rate_cps(longint'(new_pos) - longint'(trk_pos), s.elapsed_us);
            trk_raw = raw;
            trk_pos = new_pos;
        end
        r.raw_count    = trk_raw;
        r.track_count  = trk_pos;
        r.velocity_cps = trk_vel;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("tb: mismatch on %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_positions.push_back(advance_tracker(cur_sample));
                in_flight--;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_sample      = sample_queue.pop_front();
                    in_valid        <= 1'b1;
                    opcode          <= cur_sample.opcode;
                    read_ok         <= cur_sample.read_ok;
                    angle_high_byte <= cur_sample.angle_high_byte;
                    angle_low_byte  <= cur_sample.angle_low_byte;
                    elapsed_us      <= cur_sample.elapsed_us;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with a counted hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_positions.size() == 0)
            begin
                report_mismatch("unexpected result", '0, '0);
            end
            else
            begin
                position_t want;
                want = expected_positions.pop_front();
                if (fault !== want.fault)
                    report_mismatch("fault", fault, want.fault);
                if (raw_count !== want.raw_count)
                    report_mismatch("raw_count", raw_count, want.raw_count);
                if (track_count !== want.track_count)
                    report_mismatch("track_count", track_count, want.track_count);
                if (velocity_cps !== want.velocity_cps)
                    report_mismatch("velocity_cps", velocity_cps, want.velocity_cps);
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic queue_sample(logic op, logic ok, logic [emt_pkg::BYTE_W-1:0] hi,
                                logic [emt_pkg::BYTE_W-1:0] lo,
                                logic [emt_pkg::US_W-1:0] us);
        sample_t s;
        s.opcode          = op;
        s.read_ok         = ok;
        s.angle_high_byte = hi;
        s.angle_low_byte  = lo;
        s.elapsed_us      = us;
        sample_queue.push_back(s);
        in_flight++;
    endtask

    task automatic queue_raw(logic op, logic ok, int raw, logic [emt_pkg::US_W-1:0] us);
        logic [emt_pkg::BYTE_W-1:0] hi;
        hi = {4'($urandom_range(15)), 4'(raw >> 8)};
        queue_sample(op, ok, hi, 8'(raw), us);
    endtask

    task automatic write_threshold(logic [emt_pkg::RAW_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wrap_thr  = value;
    endtask

    task automatic drain();
        while (in_flight != 0 || expected_positions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [emt_pkg::US_W-1:0] pick_elapsed();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return '0;
        if (sel < 15)
            return $urandom;
        if (sel < 25)
            return $urandom_range(16, 1);
        return $urandom_range(200000, 50);
    endfunction

    // spinning shaft with occasional seeds, bus failures and odd jumps
    task automatic queue_shaft_run(int count);
        int sel;
        int dir;
        int nxt;
        dir = $urandom_range(1) ? 1 : -1;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 5)
            begin
                shaft = $urandom_range(4095);
                queue_raw(emt_pkg::OP_SEED, 1'b1, shaft, pick_elapsed());
            end
            else if (sel < 13)
            begin
                queue_sample(1'($urandom), 1'b0, 8'($urandom), 8'($urandom), $urandom);
            end
            else
            begin
                if ($urandom_range(99) < 3)
                    dir = -dir;
                sel = $urandom_range(99);
                if (sel < 60)
                    nxt = shaft + dir * $urandom_range(300);
                else if (sel < 80)
                    nxt = shaft + dir * $urandom_range(2000);
                else if (sel < 90)
                    nxt = $urandom_range(4095);
                else
                begin
                    nxt = shaft + dir * (wrap_thr + $urandom_range(1));
                    if (nxt < 0 || nxt > 4095)
                        nxt = shaft - dir * (wrap_thr + $urandom_range(1));
                end
                if (nxt < 0 || nxt > 4095)
                    nxt = nxt & 12'hFFF;
                shaft = nxt;
                queue_raw(emt_pkg::OP_UPDATE, 1'b1, shaft, pick_elapsed());
            end
        end
    endtask

    initial
    begin
        logic [emt_pkg::RAW_W-1:0] run_thr[6];
        run_thr = '{12'd0, 12'd4095, 12'd2048, 12'd0, 12'd1, emt_pkg::WRAP_RESET};
        run_thr[3] = $urandom_range(4095);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 10;
        recv_idle_pct = 71;
        write_threshold(emt_pkg::WRAP_RESET);

        // failed reads straight out of reset report the cleared state
        queue_sample(emt_pkg::OP_UPDATE, 1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        queue_sample(emt_pkg::OP_SEED, 1'b0, 8'h00, 8'h00, 32'd0);
        // seed ignores the upper nibble of the high byte
        queue_sample(emt_pkg::OP_SEED, 1'b1, 8'hF0, 8'hFF, 32'd100);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'hFF, 8'hFF, 32'd1);
        // zero elapsed time: positive, none, negative step
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h00, 8'h00, 32'd0);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h00, 8'h00, 32'd0);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h0F, 8'hFF, 32'd0);
        queue_sample(emt_pkg::OP_UPDATE, 1'b0, 8'h5A, 8'hA5, 32'd7);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h0F, 8'hFF, 32'hFFFF_FFFF);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h08, 8'h00, 32'hFFFF_FFFF);
        // jumps at and just past the wrap threshold
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h00, 8'h00, 32'd1000);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h0C, 8'hCC, 32'd1);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h00, 8'h00, 32'd1);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h0C, 8'hCD, 32'd1);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h00, 8'h00, 32'd3);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'hFC, 8'hCD, 32'd2);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h70, 8'h01, 32'd999999);
        // reseed in the middle of tracking clears the turn count
        queue_sample(emt_pkg::OP_SEED, 1'b1, 8'hAB, 8'hCD, 32'd0);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h03, 8'h00, 32'd1);
        queue_sample(emt_pkg::OP_UPDATE, 1'b1, 8'h0E, 8'h00, 32'd1000000);
        drain();
        shaft = trk_raw;

        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 71;
            end
            else if (p < 4)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_threshold(run_thr[p]);
            queue_shaft_run(RUN_ITEMS / 2);
            if (p == 4)
                rx_hold_left = HOLD_CYCLES;
            // sender waits for every result before the second half
            drain();
            queue_shaft_run(RUN_ITEMS - RUN_ITEMS / 2);
            drain();
        end

        repeat (60) @(posedge clk);
        if (expected_positions.size() != 0)
            report_mismatch("missing results", expected_positions.size(), 0);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
